### rtl/ttrr_pkg.sv
// ttrr_pkg: shared types and constants for the round-robin thread table
// holds the request/result beat structs, the table entry layout and the fsm state enum
// no dependencies
package ttrr_pkg;

  // fixed field widths of the request and result beats
  localparam int SLOT_W = 6;
  localparam int ID_W   = 32;

  // per-slot thread status
  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_JOINED  = 2'd3
  } status_t;

  // request kinds
  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_YIELD  = 2'd1,
    REQ_JOIN   = 2'd2,
    REQ_END    = 2'd3
  } req_kind_t;

  // result codes
  typedef enum logic [1:0] {
    RC_OK   = 2'd0,
    RC_FULL = 2'd1,
    RC_NONE = 2'd2
  } rc_t;

  // request beat
  typedef struct packed {
    req_kind_t         req_type;
    logic [SLOT_W-1:0] target_slot;
  } req_t;

  // result beat
  typedef struct packed {
    rc_t               result_code;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   thread_id;
    logic              switched;
    logic [SLOT_W-1:0] old_slot;
  } rsp_t;

  // one row of the thread table
  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] join_id;
  } entry_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CR_SCAN,
    S_JN_CUR,
    S_JN_TGT,
    S_JN_CHK,
    S_EN_CUR,
    S_EN_FREE,
    S_SWEEP,
    S_SCH_START,
    S_SCH_OLD,
    S_SCH_SCAN,
    S_SCH_FIN
  } sched_state_t;

endpackage

### rtl/ttrr_ram.sv
// ttrr_ram: generic simple dual-port ram, one write and one registered read port
// read returns the old contents on a same-address write
// no dependencies
module ttrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/ttrr_store.sv
// ttrr_store: thread table storage, ram plus per-slot written flags
// an unwritten slot reads as its reset contents (slot 0 running, others unused)
// depends on ttrr_pkg and ttrr_ram
module ttrr_store #(
  parameter int SLOTS = 64,
  localparam int AW = $clog2(SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output ttrr_pkg::entry_t  rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  ttrr_pkg::entry_t  wr_data
);

  localparam int EW = $bits(ttrr_pkg::entry_t);

  logic [SLOTS-1:0] written;
  logic             rd_written;
  logic             rd_zero;
  logic [EW-1:0]    ram_q;
  ttrr_pkg::entry_t rst_view;

  ttrr_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // flag lookup registered with the ram read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_written <= written[rd_addr];
      rd_zero    <= (rd_addr == '0);
    end
  end

  // reset contents of a slot never written
  always_comb begin
    rst_view.status  = rd_zero ? ttrr_pkg::ST_RUNNING : ttrr_pkg::ST_UNUSED;
    rst_view.id      = '0;
    rst_view.join_id = '0;
  end

  assign rd_data = rd_written ? ttrr_pkg::entry_t'(ram_q) : rst_view;

endmodule

### rtl/thread_table_round_robin_scheduler.sv
// thread_table_round_robin_scheduler: hardware thread table with round-robin dispatch
// sequencer over one table memory; each slot row holds status, id and join id
// depends on ttrr_pkg and ttrr_store
//
// Usage: drive a request beat on req and raise start; it is taken at a rising
// edge where start is high and busy is low. Requests are create, yield, join
// and end. Exactly one result beat follows: done is high for one cycle with the
// result on result, and it must be taken in that cycle, there is no stall.
// busy drops in the same cycle that done rises, so the next request may be
// taken then.
// The table scans do one slot read per cycle on the single memory read port:
// create scans for the lowest unused slot, yield and join scan for a ready
// slot, and end first sweeps all slots to wake joiners and then runs the
// yield scan.
// Reset is synchronous; afterwards slot 0 runs with id 0 and every other slot
// is unused. The table needs no clearing pass: per-slot written flags make
// untouched rows read as their reset contents, so a request is taken in the
// first cycle after reset.
module thread_table_round_robin_scheduler #(
  parameter int SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ttrr_pkg::req_t req,
  output logic           done,
  output ttrr_pkg::rsp_t result
);

  localparam int AW = $clog2(SLOTS);
  localparam int SW = ttrr_pkg::SLOT_W;
  localparam int IW = ttrr_pkg::ID_W;

  ttrr_pkg::sched_state_t state, state_next;

  logic [AW-1:0]    running_slot, running_slot_next;
  logic             running_valid, running_valid_next;
  logic [IW-1:0]    id_counter, id_counter_next;
  ttrr_pkg::req_t   req_q;
  logic [AW-1:0]    ptr, ptr_next;
  logic [AW:0]      left, left_next;
  logic             rd_live;
  logic             rd_last;
  logic [AW-1:0]    rd_addr;
  ttrr_pkg::entry_t old_ent, old_ent_next;
  logic [IW-1:0]    gone_id, gone_id_next;
  logic [AW-1:0]    pick, pick_next;
  logic [IW-1:0]    pick_id, pick_id_next;
  logic             respond;
  ttrr_pkg::rsp_t   rsp_next;

  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  ttrr_pkg::entry_t mem_rdata;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  ttrr_pkg::entry_t mem_wdata;

  logic             accept;
  logic             scanning;
  logic             scan_issue;
  logic [AW-1:0]    ptr_succ;
  logic [AW-1:0]    run_succ;
  logic [AW-1:0]    tgt_addr;
  logic             tgt_in_range;
  logic             old_runnable;
  logic             same_slot;

  ttrr_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  // handshake and scan helpers
  assign busy       = (state != ttrr_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign scanning   = (state == ttrr_pkg::S_CR_SCAN) || (state == ttrr_pkg::S_SWEEP) ||
                      (state == ttrr_pkg::S_SCH_SCAN);
  assign scan_issue = scanning && (left != '0);
  assign ptr_succ   = (ptr == AW'(SLOTS - 1)) ? '0 : AW'(ptr + 1'b1);
  assign run_succ   = (running_slot == AW'(SLOTS - 1)) ? '0 : AW'(running_slot + 1'b1);
  assign tgt_addr   = AW'(req_q.target_slot);
  assign tgt_in_range = (int'(req_q.target_slot) < SLOTS);
  assign old_runnable = (old_ent.status == ttrr_pkg::ST_READY) ||
                        (old_ent.status == ttrr_pkg::ST_RUNNING);
  assign same_slot    = running_valid && (pick == running_slot);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ttrr_pkg::S_IDLE: begin
        if (accept) begin
          priority if (req.req_type == ttrr_pkg::REQ_CREATE) begin
            state_next = ttrr_pkg::S_CR_SCAN;
          end else if (req.req_type == ttrr_pkg::REQ_JOIN && running_valid) begin
            state_next = ttrr_pkg::S_JN_CUR;
          end else if (req.req_type == ttrr_pkg::REQ_END && running_valid) begin
            state_next = ttrr_pkg::S_EN_CUR;
          end else begin
            state_next = ttrr_pkg::S_SCH_START;
          end
        end
      end
      ttrr_pkg::S_CR_SCAN: begin
        if (rd_live && (mem_rdata.status == ttrr_pkg::ST_UNUSED || rd_last)) begin
          state_next = ttrr_pkg::S_IDLE;
        end
      end
      ttrr_pkg::S_JN_CUR:  state_next = ttrr_pkg::S_JN_TGT;
      ttrr_pkg::S_JN_TGT:  state_next = ttrr_pkg::S_JN_CHK;
      ttrr_pkg::S_JN_CHK: begin
        if (!tgt_in_range || mem_rdata.status == ttrr_pkg::ST_UNUSED) begin
          state_next = ttrr_pkg::S_IDLE;
        end else begin
          state_next = ttrr_pkg::S_SCH_START;
        end
      end
      ttrr_pkg::S_EN_CUR:  state_next = ttrr_pkg::S_EN_FREE;
      ttrr_pkg::S_EN_FREE: state_next = ttrr_pkg::S_SWEEP;
      ttrr_pkg::S_SWEEP: begin
        if (rd_live && rd_last) begin
          state_next = ttrr_pkg::S_SCH_START;
        end
      end
      ttrr_pkg::S_SCH_START: state_next = ttrr_pkg::S_SCH_OLD;
      ttrr_pkg::S_SCH_OLD:   state_next = ttrr_pkg::S_SCH_SCAN;
      ttrr_pkg::S_SCH_SCAN: begin
        priority if (rd_live && mem_rdata.status == ttrr_pkg::ST_READY) begin
          state_next = ttrr_pkg::S_SCH_FIN;
        end else if (rd_live && rd_last) begin
          state_next = ttrr_pkg::S_IDLE;
        end else begin
          // keep scanning
          state_next = ttrr_pkg::S_SCH_SCAN;
        end
      end
      ttrr_pkg::S_SCH_FIN: state_next = ttrr_pkg::S_IDLE;
      default:             state_next = ttrr_pkg::S_IDLE;
    endcase
  end

  // table accesses, datapath updates and result
  always_comb begin
    mem_re             = 1'b0;
    mem_raddr          = ptr;
    mem_we             = 1'b0;
    mem_waddr          = rd_addr;
    mem_wdata          = old_ent;
    ptr_next           = ptr;
    left_next          = left;
    running_slot_next  = running_slot;
    running_valid_next = running_valid;
    id_counter_next    = id_counter;
    old_ent_next       = old_ent;
    gone_id_next       = gone_id;
    pick_next          = pick;
    pick_id_next       = pick_id;
    respond            = 1'b0;
    rsp_next           = '0;

    // one scan read per cycle
    if (scan_issue) begin
      mem_re    = 1'b1;
      mem_raddr = ptr;
      ptr_next  = ptr_succ;
      left_next = left - 1'b1;
    end

    unique case (state)
      ttrr_pkg::S_IDLE: begin
        if (accept) begin
          ptr_next  = '0;
          left_next = (AW+1)'(SLOTS);
        end
      end
      // lowest unused slot gets the next id
      ttrr_pkg::S_CR_SCAN: begin
        if (rd_live) begin
          priority if (mem_rdata.status == ttrr_pkg::ST_UNUSED) begin
            mem_we          = 1'b1;
            mem_waddr       = rd_addr;
            mem_wdata       = '{status: ttrr_pkg::ST_READY, id: id_counter + 1'b1,
                                join_id: '0};
            id_counter_next = id_counter + 1'b1;
            respond         = 1'b1;
            rsp_next        = '{result_code: ttrr_pkg::RC_OK, slot: SW'(rd_addr),
                                thread_id: id_counter + 1'b1, switched: 1'b0,
                                old_slot: SW'(running_slot)};
          end else if (rd_last) begin
            respond  = 1'b1;
            rsp_next = '{result_code: ttrr_pkg::RC_FULL, slot: '0, thread_id: '0,
                         switched: 1'b0, old_slot: SW'(running_slot)};
          end else begin
            // slot taken, keep scanning
          end
        end
      end
      ttrr_pkg::S_JN_CUR: begin
        mem_re    = 1'b1;
        mem_raddr = running_slot;
      end
      ttrr_pkg::S_JN_TGT: begin
        old_ent_next = mem_rdata;
        mem_re       = 1'b1;
        mem_raddr    = tgt_addr;
      end
      // block the running thread on the target id, or do nothing
      ttrr_pkg::S_JN_CHK: begin
        if (!tgt_in_range || mem_rdata.status == ttrr_pkg::ST_UNUSED) begin
          respond  = 1'b1;
          rsp_next = '{result_code: ttrr_pkg::RC_OK, slot: SW'(running_slot),
                       thread_id: old_ent.id, switched: 1'b0,
                       old_slot: SW'(running_slot)};
        end else begin
          mem_we    = 1'b1;
          mem_waddr = running_slot;
          mem_wdata = '{status: ttrr_pkg::ST_JOINED, id: old_ent.id,
                        join_id: mem_rdata.id};
        end
      end
      ttrr_pkg::S_EN_CUR: begin
        mem_re    = 1'b1;
        mem_raddr = running_slot;
      end
      // free the running slot and start the joiner sweep
      ttrr_pkg::S_EN_FREE: begin
        gone_id_next = mem_rdata.id;
        mem_we       = 1'b1;
        mem_waddr    = running_slot;
        mem_wdata    = '{status: ttrr_pkg::ST_UNUSED, id: mem_rdata.id,
                         join_id: mem_rdata.join_id};
        ptr_next     = '0;
        left_next    = (AW+1)'(SLOTS);
      end
      // wake threads joined on the ended id
      ttrr_pkg::S_SWEEP: begin
        if (rd_live && mem_rdata.status == ttrr_pkg::ST_JOINED &&
            mem_rdata.join_id == gone_id) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr;
          mem_wdata = '{status: ttrr_pkg::ST_READY, id: mem_rdata.id,
                        join_id: mem_rdata.join_id};
        end
      end
      ttrr_pkg::S_SCH_START: begin
        mem_re    = 1'b1;
        mem_raddr = running_slot;
      end
      ttrr_pkg::S_SCH_OLD: begin
        old_ent_next = mem_rdata;
        ptr_next     = run_succ;
        left_next    = (AW+1)'(SLOTS);
      end
      // circular scan for a ready slot after the running one
      ttrr_pkg::S_SCH_SCAN: begin
        if (rd_live) begin
          priority if (mem_rdata.status == ttrr_pkg::ST_READY) begin
            mem_we       = 1'b1;
            mem_waddr    = rd_addr;
            mem_wdata    = '{status: ttrr_pkg::ST_RUNNING, id: mem_rdata.id,
                             join_id: mem_rdata.join_id};
            pick_next    = rd_addr;
            pick_id_next = mem_rdata.id;
          end else if (rd_last) begin
            respond = 1'b1;
            if (running_valid && old_runnable) begin
              mem_we    = 1'b1;
              mem_waddr = running_slot;
              mem_wdata = '{status: ttrr_pkg::ST_RUNNING, id: old_ent.id,
                            join_id: old_ent.join_id};
              rsp_next  = '{result_code: ttrr_pkg::RC_OK, slot: SW'(running_slot),
                            thread_id: old_ent.id, switched: 1'b0,
                            old_slot: SW'(running_slot)};
            end else begin
              running_valid_next = 1'b0;
              rsp_next = '{result_code: ttrr_pkg::RC_NONE, slot: SW'(running_slot),
                           thread_id: '0, switched: 1'b0,
                           old_slot: SW'(running_slot)};
            end
          end else begin
            // slot not ready, keep scanning
          end
        end
      end
      // demote the previous thread and switch, or report no switch if the pick is the running slot
      ttrr_pkg::S_SCH_FIN: begin
        respond = 1'b1;
        if (same_slot) begin
          rsp_next = '{result_code: ttrr_pkg::RC_OK, slot: SW'(running_slot),
                       thread_id: old_ent.id, switched: 1'b0,
                       old_slot: SW'(running_slot)};
        end else begin
          if (running_valid && old_ent.status == ttrr_pkg::ST_RUNNING) begin
            mem_we    = 1'b1;
            mem_waddr = running_slot;
            mem_wdata = '{status: ttrr_pkg::ST_READY, id: old_ent.id,
                          join_id: old_ent.join_id};
          end
          running_slot_next  = pick;
          running_valid_next = 1'b1;
          rsp_next = '{result_code: ttrr_pkg::RC_OK, slot: SW'(pick),
                       thread_id: pick_id, switched: 1'b1,
                       old_slot: SW'(running_slot)};
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ttrr_pkg::S_IDLE;
      running_slot  <= '0;
      running_valid <= 1'b1;
      id_counter    <= '0;
      left          <= '0;
      rd_live       <= 1'b0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      running_slot  <= running_slot_next;
      running_valid <= running_valid_next;
      id_counter    <= id_counter_next;
      left          <= left_next;
      rd_live       <= scan_issue;
      done          <= respond;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    old_ent <= old_ent_next;
    gone_id <= gone_id_next;
    pick    <= pick_next;
    pick_id <= pick_id_next;
    if (scan_issue) begin
      rd_addr <= ptr;
      rd_last <= (left == (AW+1)'(1));
    end
    if (accept) begin
      req_q <= req;
    end
    if (respond) begin
      result <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // a result beat only closes a request in flight
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result beat without a request in flight");

  // a taken request always starts work
  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("request taken but sequencer stayed idle");

  // no same-row read and write in one cycle
  assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re && mem_waddr == mem_raddr))
    else $error("table read and write collide on one row");

  // id counter moves only on a successful create
  assert property (@(posedge clk) disable iff (rst)
    !$stable(id_counter) |-> ($past(state) == ttrr_pkg::S_CR_SCAN) && done)
    else $error("id counter changed outside create");

  // a switch is always a successful dispatch
  assert property (@(posedge clk) disable iff (rst)
    (done && result.switched) |-> (result.result_code == ttrr_pkg::RC_OK) && running_valid)
    else $error("switch reported without a running thread");
`endif

endmodule
